@@ hdl/assert_macros.svh @@
// Assertion macros shared by the escape run-length encoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising aclk edge, masked while aresetn is low
`define ERLE_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Condition that must never be seen
`define ERLE_NEVER(name, expr, msg) \
    `ERLE_ASSERT(name, !(expr), msg)

`endif

@@ hdl/erle_pkg.sv @@
// Shared types, constants and helpers of the escape run-length encoder
`default_nettype none

package erle_pkg;

    localparam logic [7:0] ESC_BYTE    = 8'hFF;
    localparam logic [7:0] MAX_RUN     = 8'd255;
    localparam logic [7:0] MIN_ESC_RUN = 8'd4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam logic [FIFO_AW:0] FIFO_FULL_COUNT = (FIFO_AW + 1)'(FIFO_DEPTH);

    typedef enum logic {
        MODE_LITERAL,
        MODE_TRIPLE
    } flush_mode_t;

    // One run to write out: len copies of sym, or ESC, sym, len
    typedef struct packed {
        logic [7:0]  sym;
        logic [7:0]  len;
        flush_mode_t mode;
    } flush_t;

    // Work for the back end from one input item; part a always present
    typedef struct packed {
        flush_t a;
        flush_t b;
        logic   b_valid;
        logic   eos;
    } cmd_t;

    function automatic flush_t make_flush(input logic [7:0] sym, input logic [7:0] len,
                                          input logic is_final);
        flush_t f;
        f.sym  = sym;
        f.len  = len;
        // a lone 0xFF closing the stream goes out bare
        if ((sym == ESC_BYTE && !(is_final && len == 8'd1)) || len >= MIN_ESC_RUN) begin
            f.mode = MODE_TRIPLE;
        end else begin
            f.mode = MODE_LITERAL;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

@@ hdl/erle_front.sv @@
// Front end: run tracking and classification of each input item into a command
`default_nettype none
`include "assert_macros.svh"

module erle_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] data_byte
    input  wire logic          s_tlast,   // end_of_stream
    input  wire logic          q_full,
    output logic               q_push,
    output erle_pkg::cmd_t     q_cmd
);
    import erle_pkg::*;

    logic [7:0] run_symbol_reg, run_symbol_next;
    logic [7:0] run_length_reg, run_length_next;
    logic       run_valid_reg,  run_valid_next;
    logic       accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        run_symbol_next = run_symbol_reg;
        run_length_next = run_length_reg;
        run_valid_next  = run_valid_reg;
        q_push          = 1'b0;
        q_cmd           = '0;
        q_cmd.eos       = s_tlast;
        if (accept) begin
            if (!run_valid_reg || run_length_reg == 8'd0) begin
                run_symbol_next = s_tdata;
                run_length_next = 8'd1;
                run_valid_next  = 1'b1;
                if (s_tlast) begin
                    q_push  = 1'b1;
                    q_cmd.a = make_flush(s_tdata, 8'd1, 1'b1);
                end
            end else if (s_tdata == run_symbol_reg) begin
                if (run_length_reg >= MAX_RUN) begin
                    // full run extended: emit it now, restart at one
                    q_push          = 1'b1;
                    q_cmd.a         = make_flush(run_symbol_reg, MAX_RUN, 1'b0);
                    run_length_next = 8'd1;
                    if (s_tlast) begin
                        q_cmd.b_valid = 1'b1;
                        q_cmd.b       = make_flush(run_symbol_reg, 8'd1, 1'b1);
                    end
                end else begin
                    run_length_next = run_length_reg + 8'd1;
                    if (s_tlast) begin
                        q_push  = 1'b1;
                        q_cmd.a = make_flush(run_symbol_reg, run_length_reg + 8'd1, 1'b1);
                    end
                end
            end else begin
                q_push          = 1'b1;
                q_cmd.a         = make_flush(run_symbol_reg, run_length_reg, 1'b0);
                run_symbol_next = s_tdata;
                run_length_next = 8'd1;
                if (s_tlast) begin
                    q_cmd.b_valid = 1'b1;
                    q_cmd.b       = make_flush(s_tdata, 8'd1, 1'b1);
                end
            end
            if (s_tlast) begin
                run_symbol_next = 8'd0;
                run_length_next = 8'd0;
                run_valid_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_symbol_reg <= 8'd0;
            run_length_reg <= 8'd0;
            run_valid_reg  <= 1'b0;
        end else begin
            run_symbol_reg <= run_symbol_next;
            run_length_reg <= run_length_next;
            run_valid_reg  <= run_valid_next;
        end
    end

    `ERLE_ASSERT(a_eos_clears_run, (accept && s_tlast) |=> !run_valid_reg, "run kept after eos")
    `ERLE_ASSERT(a_valid_run_len, run_valid_reg |-> (run_length_reg != 8'd0), "empty valid run")
    `ERLE_ASSERT(a_push_len, q_push |-> (q_cmd.a.len != 8'd0), "command with zero-length run")

endmodule

`default_nettype wire

@@ hdl/erle_fifo.sv @@
// Short command queue between front and back end
`default_nettype none
`include "assert_macros.svh"

module erle_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire erle_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output erle_pkg::cmd_t      head,
    output logic                empty
);
    import erle_pkg::*;

    cmd_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg,  count_next;

    assign full  = (count_reg == FIFO_FULL_COUNT);
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ERLE_NEVER(a_no_overflow, push && full, "push into full queue")
    `ERLE_NEVER(a_no_underflow, pop && empty, "pop from empty queue")
    `ERLE_NEVER(a_count_range, count_reg > FIFO_FULL_COUNT, "queue count out of range")

endmodule

`default_nettype wire

@@ hdl/erle_back.sv @@
// Back end: expands queued commands into output bytes behind an output register
`default_nettype none
`include "assert_macros.svh"

module erle_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire erle_pkg::cmd_t head,
    input  wire logic           q_empty,
    output logic                q_pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,   // [7:0] out_byte
    output logic                m_tlast,   // last_of_burst
    output logic                m_tuser    // stream_done
);
    import erle_pkg::*;

    logic       part_reg, part_next;   // 0: run a, 1: run b
    logic [1:0] idx_reg,  idx_next;    // byte within current run
    logic       valid_reg, valid_next;
    logic [7:0] data_reg,  data_next;
    logic       last_reg,  last_next;
    logic       done_reg,  done_next;

    flush_t     cur;
    logic [7:0] cur_byte;
    logic       part_end;
    logic       cmd_end;
    logic       load;

    assign cur  = part_reg ? head.b : head.a;
    assign load = !q_empty && (!valid_reg || m_tready);

    always_comb begin
        if (cur.mode == MODE_TRIPLE) begin
            case (idx_reg)
                2'd0:    cur_byte = ESC_BYTE;
                2'd1:    cur_byte = cur.sym;
                default: cur_byte = cur.len;
            endcase
            part_end = (idx_reg == 2'd2);
        end else begin
            cur_byte = cur.sym;
            part_end = ({6'd0, idx_reg} + 8'd1 == cur.len);
        end
        cmd_end = part_end && (part_reg || !head.b_valid);
    end

    always_comb begin
        part_next  = part_reg;
        idx_next   = idx_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        valid_next = valid_reg && !m_tready;
        q_pop      = load && cmd_end;
        if (load) begin
            valid_next = 1'b1;
            data_next  = cur_byte;
            last_next  = cmd_end;
            done_next  = cmd_end && head.eos;
            if (part_end) begin
                idx_next  = 2'd0;
                part_next = !cmd_end;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_reg  <= 1'b0;
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            part_reg  <= part_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

    `ERLE_NEVER(a_idx_range, idx_reg == 2'd3, "byte index past a triple")
    `ERLE_ASSERT(a_done_is_last, (valid_reg && done_reg) |-> last_reg, "stream end not on burst end")
    `ERLE_ASSERT(a_pop_resets_seq, q_pop |=> (idx_reg == 2'd0 && !part_reg),
                 "sequencer not rewound after command")

endmodule

`default_nettype wire

@@ hdl/escape_run_length_encoder.sv @@
// Escape-byte run-length encoder top level
//
// Input stream (s_*): one raw byte per item in s_tdata, s_tlast marks the
// final byte of a stream. Output stream (m_*): one compressed byte per item;
// m_tlast marks the last byte caused by one input item, m_tuser the last
// byte of the whole compressed stream.
// Runs shorter than four of a byte other than 0xFF go out as literal copies,
// other runs as 0xFF, symbol, count; a lone 0xFF ending the stream goes out bare.
// Throughput: one input item per cycle while the four-entry command queue
// has room, one output byte per cycle while m_tready is high. An item causes
// 0 to 4 output bytes, so the output port (one byte per cycle) sets the
// sustained input rate when runs end often.
// With the queue empty and the output register free, the first byte caused
// by an item is registered in the command queue, then in the output register.
// Reset (aresetn low, synchronous) drops the held run, the queue and any
// pending output. When m_tready is low the output register holds; the queue
// keeps taking items until it fills, then s_tready falls.
`default_nettype none

module escape_run_length_encoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // end_of_stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,   // last_of_burst
    output logic            m_tuser    // stream_done
);
    import erle_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_cmd;
    cmd_t q_head;

    erle_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    erle_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    erle_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
